// ===== rtl/core/lmcm_pkg.sv =====
// lmcm_pkg: widths, codes, pipeline records and the restoring divide step
// shared by every file of the led matrix coordinate mapper
// no dependencies
package lmcm_pkg;

  localparam int unsigned MAX_SIDE = 128;
  localparam int unsigned SIDE_W   = 8;
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned IDX_W    = 14;
  localparam int unsigned TOTAL_W  = 15;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SIDE_W-1:0] RST_WIDTH  = 8'd8;
  localparam logic [SIDE_W-1:0] RST_HEIGHT = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LAYOUT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    LAYOUT_LINEAR = 2'd0,
    LAYOUT_ZIGZAG = 2'd1,
    LAYOUT_SNAKE  = 2'd2
  } layout_t;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_t;

  // settled geometry, as seen by the front and back stages
  typedef struct packed {
    logic [SIDE_W-1:0]  w;
    logic [SIDE_W-1:0]  h;
    logic               serp;
    logic [TOTAL_W-1:0] total;
  } geom_t;

  // first stage: the request as taken
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] idx;
  } req_t;

  // later stages: forward sum and divider state side by side
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic               ok;
    logic [IDX_W-1:0]   acc;
    logic [COORD_W-1:0] fcol;
    logic [IDX_W-1:0]   rem;
    logic [COORD_W-1:0] quo;
  } pipe_t;

  typedef struct packed {
    logic [IDX_W-1:0] rem;
    logic             qbit;
  } div_t;

  // one restoring step against w shifted up by k
  function automatic div_t div_step(input logic [IDX_W-1:0] rem,
                                    input logic [SIDE_W-1:0] w,
                                    input int unsigned k);
    logic [TOTAL_W-1:0] d;
    div_t res;
    d = TOTAL_W'(w) << k;
    if ({1'b0, rem} >= d) begin
      res.rem  = rem - d[IDX_W-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/led_matrix_coordinate_mapper_core.sv =====
// led_matrix_coordinate_mapper_core: top level of the coordinate mapper
// depends on lmcm_pkg, lmcm_cfg, lmcm_front, lmcm_back
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   request  | in_opcode in_col in_row in_index        | start high, busy low
//   result   | out_index out_col out_row out_in_range  | out_valid, one cycle
//   config   | cfg_index cfg_data                      | cfg_valid and cfg_ready
//
// one request per clock while busy is low; the result is registered through
// the five register stages of the shared divide path
// (request, two divide steps per middle stage, last step plus result register)
// busy is high only during reset and the cycle that follows it
// reset clears all valid bits and restores an 8 by 8 linear matrix
// the receiver cannot stall; cfg_ready is always high
module led_matrix_coordinate_mapper_core import lmcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  logic [FIELD_W-1:0]   in_col,
  input  logic [FIELD_W-1:0]   in_row,
  input  logic [FIELD_W-1:0]   in_index,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     out_index,
  output logic [COORD_W-1:0]   out_col,
  output logic [COORD_W-1:0]   out_row,
  output logic                 out_in_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data
);

  logic  busy_r;
  req_t  a_r;
  geom_t geom;
  pipe_t b_pipe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      a_r.valid <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      a_r.valid <= start && !busy_r;
    end
    a_r.op  <= op_t'(in_opcode);
    a_r.col <= in_col;
    a_r.row <= in_row;
    a_r.idx <= in_index;
  end

  lmcm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .geom    (geom)
  );

  lmcm_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .geom  (geom),
    .req   (a_r),
    .pipe  (b_pipe)
  );

  lmcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .pipe      (b_pipe),
    .res_valid (out_valid),
    .res_index (out_index),
    .res_col   (out_col),
    .res_row   (out_row),
    .res_ok    (out_in_range)
  );

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/lmcm_cfg.sv =====
// lmcm_cfg: configuration registers and the settled geometry derived from them
// depends on lmcm_pkg
module lmcm_cfg import lmcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [SIDE_W-1:0]    wr_data,
  output geom_t                geom
);

  logic [SIDE_W-1:0] width_r;
  logic [SIDE_W-1:0] height_r;
  logic [1:0]        layout_r;
  geom_t             geom_r;
  geom_t             geom_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      layout_r <= LAYOUT_LINEAR;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_WIDTH:  width_r  <= wr_data;
        REG_HEIGHT: height_r <= wr_data;
        REG_LAYOUT: layout_r <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // sides saturate at the largest matrix; any non-linear code is serpentine
  always_comb begin
    geom_nxt.w     = (width_r  > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_r;
    geom_nxt.h     = (height_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_r;
    geom_nxt.serp  = (layout_r != LAYOUT_LINEAR);
    geom_nxt.total = TOTAL_W'(geom_nxt.w) * TOTAL_W'(geom_nxt.h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.w     <= RST_WIDTH;
      geom_r.h     <= RST_HEIGHT;
      geom_r.serp  <= 1'b0;
      geom_r.total <= TOTAL_W'(RST_WIDTH) * TOTAL_W'(RST_HEIGHT);
    end else begin
      geom_r <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

// ===== rtl/core/lmcm_front.sv =====
// lmcm_front: range check, row product, column mirror and the two top divide steps
// depends on lmcm_pkg
module lmcm_front import lmcm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  geom_t geom,
  input  req_t  req,
  output pipe_t pipe
);

  pipe_t b_r;
  pipe_t b_nxt;

  always_comb begin
    logic [SIDE_W-1:0] mcol;
    div_t              s6;
    div_t              s5;
    b_nxt       = '0;
    b_nxt.valid = req.valid;
    b_nxt.op    = req.op;
    if (req.op == OP_FWD) begin
      b_nxt.ok = (req.col < FIELD_W'(geom.w)) && (req.row < FIELD_W'(geom.h));
    end else begin
      b_nxt.ok = (req.idx < FIELD_W'(geom.total));
    end
    mcol = req.col[SIDE_W-1:0];
    if (geom.serp && req.row[0]) begin
      mcol = geom.w - 8'd1 - req.col[SIDE_W-1:0];
    end
    b_nxt.fcol = mcol[COORD_W-1:0];
    b_nxt.acc  = IDX_W'(req.row[COORD_W-1:0]) * IDX_W'(geom.w);
    s6 = div_step(req.idx[IDX_W-1:0], geom.w, 6);
    s5 = div_step(s6.rem, geom.w, 5);
    b_nxt.rem    = s5.rem;
    b_nxt.quo[6] = s6.qbit;
    b_nxt.quo[5] = s5.qbit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else begin
      b_r.valid <= b_nxt.valid;
    end
    b_r.op   <= b_nxt.op;
    b_r.ok   <= b_nxt.ok;
    b_r.acc  <= b_nxt.acc;
    b_r.fcol <= b_nxt.fcol;
    b_r.rem  <= b_nxt.rem;
    b_r.quo  <= b_nxt.quo;
  end

  assign pipe = b_r;

endmodule

// ===== rtl/core/lmcm_back.sv =====
// lmcm_back: forward add, remaining divide steps, un-mirror and the result register
// depends on lmcm_pkg
module lmcm_back import lmcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  geom_t              geom,
  input  pipe_t              pipe,
  output logic               res_valid,
  output logic [IDX_W-1:0]   res_index,
  output logic [COORD_W-1:0] res_col,
  output logic [COORD_W-1:0] res_row,
  output logic               res_ok
);

  pipe_t c_r, c_nxt;
  pipe_t d_r, d_nxt;

  logic               valid_r;
  logic [IDX_W-1:0]   index_r, index_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               ok_r;

  always_comb begin
    div_t s4;
    div_t s3;
    c_nxt     = pipe;
    c_nxt.acc = pipe.acc + IDX_W'(pipe.fcol);
    s4 = div_step(pipe.rem, geom.w, 4);
    s3 = div_step(s4.rem, geom.w, 3);
    c_nxt.rem    = s3.rem;
    c_nxt.quo[4] = s4.qbit;
    c_nxt.quo[3] = s3.qbit;
  end

  always_comb begin
    div_t s2;
    div_t s1;
    d_nxt = c_r;
    s2 = div_step(c_r.rem, geom.w, 2);
    s1 = div_step(s2.rem, geom.w, 1);
    d_nxt.rem    = s1.rem;
    d_nxt.quo[2] = s2.qbit;
    d_nxt.quo[1] = s1.qbit;
  end

  always_comb begin
    div_t              s0;
    logic [SIDE_W-1:0] ucol;
    logic [COORD_W-1:0] quo;
    s0     = div_step(d_r.rem, geom.w, 0);
    quo    = {d_r.quo[6:1], s0.qbit};
    ucol   = SIDE_W'(s0.rem);
    // odd rows of serpentine layouts run backwards
    if (geom.serp && s0.qbit) begin
      ucol = geom.w - 8'd1 - SIDE_W'(s0.rem);
    end
    index_nxt = '0;
    col_nxt   = '0;
    row_nxt   = '0;
    if (d_r.ok) begin
      if (d_r.op == OP_FWD) begin
        index_nxt = d_r.acc;
      end else begin
        col_nxt = ucol[COORD_W-1:0];
        row_nxt = quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
      d_r.valid <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      c_r.valid <= c_nxt.valid;
      d_r.valid <= d_nxt.valid;
      valid_r   <= d_r.valid;
    end
    c_r.op   <= c_nxt.op;
    c_r.ok   <= c_nxt.ok;
    c_r.acc  <= c_nxt.acc;
    c_r.fcol <= c_nxt.fcol;
    c_r.rem  <= c_nxt.rem;
    c_r.quo  <= c_nxt.quo;
    d_r.op   <= d_nxt.op;
    d_r.ok   <= d_nxt.ok;
    d_r.acc  <= d_nxt.acc;
    d_r.fcol <= d_nxt.fcol;
    d_r.rem  <= d_nxt.rem;
    d_r.quo  <= d_nxt.quo;
    index_r  <= index_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    ok_r     <= d_r.ok;
  end

  assign res_valid = valid_r;
  assign res_index = index_r;
  assign res_col   = col_r;
  assign res_row   = row_r;
  assign res_ok    = ok_r;

endmodule

// ===== rtl/core/lmcm_checker.sv =====
// lmcm_checker: port-level checks on the coordinate mapper, bound to the top level
// depends on lmcm_pkg and led_matrix_coordinate_mapper_core
module lmcm_checker import lmcm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [IDX_W-1:0]     out_index,
  input logic [COORD_W-1:0]   out_col,
  input logic [COORD_W-1:0]   out_row,
  input logic                 out_in_range
);

  // every request gives exactly one result at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("request without result");

  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without request");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_index == '0 && out_col == '0 && out_row == '0))
    else $error("out of range result not zero");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index != '0) |-> (out_col == '0 && out_row == '0))
    else $error("forward and inverse fields both set");

endmodule

bind led_matrix_coordinate_mapper_core lmcm_checker u_lmcm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_index    (out_index),
  .out_col      (out_col),
  .out_row      (out_row),
  .out_in_range (out_in_range)
);
